/* hdl/ilid_pkg.sv */
// shared types and constants for the indexed list insert/delete block
// no dependencies; imported by ilid_decode and indexed_list_insert_delete
package ilid_pkg;

    typedef enum logic [2:0] {
        CMD_READ   = 3'd0,
        CMD_HEAD   = 3'd1,
        CMD_TAIL   = 3'd2,
        CMD_BEFORE = 3'd3,
        CMD_DELETE = 3'd4
    } cmd_e;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_e;

    localparam int COUNT_W = 7;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 16;

    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic [2:0]              command;
        logic signed [POS_W-1:0] position;
        logic signed [DATA_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [1:0]               status;
        logic [COUNT_W-1:0]       count;
    } rsp_word_t;

    // decoded action for one command word
    typedef struct packed {
        logic    ins;
        logic    del;
        logic    rd_hit;
        logic    rd_miss;
        status_e status;
    } ctl_t;

endpackage

/* hdl/indexed_list_insert_delete.sv */
// Position-indexed list of up to CAPACITY signed 32-bit entries, entry 0 at
// the head. Each command word (read, insert at head, insert at tail, insert
// before a position, delete at a position) gives exactly one response word
// with the read value, a status and the entry count after the command. A
// command word is registered on accept, then decoded and applied as it
// moves to the response register; each entry at or past the target index
// shifts up or down by one through its own mux, so one command word
// completes per cycle unless rsp_stall holds a waiting response. The
// response register decouples the sides: a new command is taken while an
// earlier response waits.
// depends on ilid_pkg and ilid_decode
module indexed_list_insert_delete
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_word_t rsp_word
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic            cmd_full_reg;
    logic            cmd_full_next;
    cmd_word_t       cmd_word_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_word_t       rsp_word_reg;
    rsp_word_t       rsp_word_next;
    logic [LW-1:0]   length_reg;
    logic [LW-1:0]   length_next;
    logic [DATA_W-1:0] entries_reg  [CAPACITY];
    logic [DATA_W-1:0] entries_next [CAPACITY];

    logic            advance;
    logic            accept;
    ctl_t            ctl;
    logic [IW-1:0]   idx;

    assign advance   = cmd_full_reg && (!rsp_valid_reg || !rsp_stall);
    assign cmd_stall = cmd_full_reg && !advance;
    assign accept    = cmd_valid && !cmd_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    ilid_decode #(
        .CAPACITY(CAPACITY)
    ) u_decode (
        .word   (cmd_word_reg),
        .length (length_reg),
        .ctl    (ctl),
        .idx    (idx)
    );

    // per-cell shift muxes
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [DATA_W-1:0] up_src;
        logic [DATA_W-1:0] dn_src;

        if (i == 0)
        begin : g_first
            assign up_src = cmd_word_reg.value;
        end
        else
        begin : g_up
            assign up_src = entries_reg[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign dn_src = entries_reg[i];
        end
        else
        begin : g_dn
            assign dn_src = entries_reg[i+1];
        end

        always_comb
        begin
            entries_next[i] = entries_reg[i];
            if (ctl.ins)
            begin
                if (IW'(i) == idx)
                begin
                    entries_next[i] = cmd_word_reg.value;
                end
                else if (IW'(i) > idx)
                begin
                    entries_next[i] = up_src;
                end
            end
            else if (ctl.del && (IW'(i) >= idx))
            begin
                entries_next[i] = dn_src;
            end
        end
    end

    always_comb
    begin
        priority if (ctl.ins)
        begin
            length_next = length_reg + LW'(1);
        end
        else if (ctl.del)
        begin
            length_next = length_reg - LW'(1);
        end
        else
        begin
            length_next = length_reg;
        end

        rsp_word_next.status = ctl.status;
        rsp_word_next.count  = COUNT_W'(length_next);
        priority if (ctl.rd_hit)
        begin
            rsp_word_next.read_value = entries_reg[idx];
        end
        else if (ctl.rd_miss)
        begin
            rsp_word_next.read_value = MISS_VALUE;
        end
        else
        begin
            rsp_word_next.read_value = '0;
        end

        priority if (accept)
        begin
            cmd_full_next = 1'b1;
        end
        else if (advance)
        begin
            cmd_full_next = 1'b0;
        end
        else
        begin
            cmd_full_next = cmd_full_reg;
        end

        priority if (advance)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_full_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            length_reg    <= '0;
        end
        else
        begin
            cmd_full_reg  <= cmd_full_next;
            rsp_valid_reg <= rsp_valid_next;
            if (advance)
            begin
                length_reg <= length_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_word_reg <= cmd_word;
        end
        if (advance)
        begin
            rsp_word_reg <= rsp_word_next;
            entries_reg  <= entries_next;
        end
    end

`ifndef SYNTHESIS
    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        LW'(CAPACITY) >= length_reg)
        else $error("list length above capacity");

    a_ins_del_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.ins && ctl.del))
        else $error("insert and delete decoded together");

    a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
        advance && ctl.ins |=> length_reg == $past(length_reg) + LW'(1))
        else $error("insert did not grow the list by one");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_word_reg.status == ST_FULL) |-> length_reg == LW'(CAPACITY))
        else $error("full status while list not full");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_word_reg.count == COUNT_W'(length_reg))
        else $error("response count differs from list length");
`endif

endmodule

/* hdl/ilid_decode.sv */
// command decode: range and capacity checks and the target index
// depends on ilid_pkg
module ilid_decode
    import ilid_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  cmd_word_t                      word,
    input  logic [$clog2(CAPACITY+1)-1:0]  length,
    output ctl_t                           ctl,
    output logic [$clog2(CAPACITY)-1:0]    idx
);

    localparam int LW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (LW > POS_W - 1) ? LW : POS_W - 1;

    logic          pos_neg;
    logic [CW-1:0] pos_mag;
    logic [CW-1:0] len_ext;
    logic          in_range;
    logic          past_end;
    logic          pos_above_zero;
    logic          full;

    assign pos_neg        = word.position[POS_W-1];
    assign pos_mag        = CW'(word.position[POS_W-2:0]);
    assign len_ext        = CW'(length);
    assign in_range       = !pos_neg && (pos_mag < len_ext);
    assign past_end       = !pos_neg && (pos_mag > len_ext);
    assign pos_above_zero = !pos_neg && (pos_mag != '0);
    assign full           = (len_ext == CW'(CAPACITY));

    always_comb
    begin
        ctl.ins     = 1'b0;
        ctl.del     = 1'b0;
        ctl.rd_hit  = 1'b0;
        ctl.rd_miss = 1'b0;
        ctl.status  = ST_DONE;
        idx         = pos_mag[IW-1:0];
        unique case (cmd_e'(word.command))
            CMD_READ:
            begin
                if (in_range)
                begin
                    ctl.rd_hit = 1'b1;
                end
                else
                begin
                    ctl.rd_miss = 1'b1;
                    ctl.status  = ST_BADPOS;
                end
            end
            CMD_HEAD:
            begin
                idx = '0;
                if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                end
            end
            CMD_TAIL:
            begin
                // only used when not full, so length fits the index
                idx = length[IW-1:0];
                if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                end
            end
            CMD_BEFORE:
            begin
                idx = pos_above_zero ? pos_mag[IW-1:0] : '0;
                priority if (past_end)
                begin
                    ctl.status = ST_BADPOS;
                end
                else if (full)
                begin
                    ctl.status = ST_FULL;
                end
                else
                begin
                    ctl.ins = 1'b1;
                end
            end
            CMD_DELETE:
            begin
                if (in_range)
                begin
                    ctl.del = 1'b1;
                end
                else
                begin
                    ctl.status = ST_BADPOS;
                end
            end
            default:
            begin
                ctl.status = ST_DONE;
            end
        endcase
    end

endmodule
